### rtl/rcke_pkg.sv
// shared types, constants and helpers for the rolling canonical k-mer extractor
package rcke_pkg;

   localparam int POSITION_WIDTH_DEFAULT = 32;
   localparam int MAX_KMER_DEFAULT = 32;
   localparam int WINDOW_WIDTH = 64;
   localparam int PAIR_COUNT = WINDOW_WIDTH / 2;
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH = 32;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_KMER_LENGTH = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_CANONICAL_MODE = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SEED_FAMILY = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DOCUMENT_NUMBER = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SEQUENCE_NUMBER = 3'd4;

   localparam logic [5:0] KMER_LENGTH_RESET = 6'd21;
   localparam logic CANONICAL_MODE_RESET = 1'b1;
   localparam logic [5:0] RUN_LIMIT = 6'd32;

   localparam logic [7:0] CHAR_A_UPPER = 8'h41;
   localparam logic [7:0] CHAR_A_LOWER = 8'h61;
   localparam logic [7:0] CHAR_C_UPPER = 8'h43;
   localparam logic [7:0] CHAR_C_LOWER = 8'h63;
   localparam logic [7:0] CHAR_G_UPPER = 8'h47;
   localparam logic [7:0] CHAR_G_LOWER = 8'h67;
   localparam logic [7:0] CHAR_T_UPPER = 8'h54;
   localparam logic [7:0] CHAR_T_LOWER = 8'h74;

   localparam logic [1:0] BASE_A = 2'd0;
   localparam logic [1:0] BASE_C = 2'd1;
   localparam logic [1:0] BASE_G = 2'd2;
   localparam logic [1:0] BASE_T = 2'd3;

   typedef struct packed {
      logic [5:0]  kmer_length;
      logic        canonical_mode;
      logic [7:0]  seed_family;
      logic [31:0] document_number;
      logic [31:0] sequence_number;
   } cfg_type;

   typedef struct packed {
      logic [WINDOW_WIDTH-1:0] seed_value;
      logic                    seed_strand;
      logic [31:0]             start_position;
      logic [7:0]              family_tag;
      logic [5:0]              seed_length;
      logic [31:0]             document_tag;
      logic [31:0]             sequence_tag;
   } seed_type;

   typedef struct packed {
      logic       is_base;
      logic [1:0] code;
   } base_type;

   // ascii nucleotide to 2-bit code, either case
   function automatic base_type base_decode(input logic [7:0] ch);
      base_type res;
      res.is_base = 1'b1;
      res.code = BASE_A;
      unique case (ch)
         CHAR_A_UPPER, CHAR_A_LOWER: res.code = BASE_A;
         CHAR_C_UPPER, CHAR_C_LOWER: res.code = BASE_C;
         CHAR_G_UPPER, CHAR_G_LOWER: res.code = BASE_G;
         CHAR_T_UPPER, CHAR_T_LOWER: res.code = BASE_T;
         default: res.is_base = 1'b0;
      endcase
      return res;
   endfunction

endpackage

### rtl/rcke_if.sv
// request, result and register-write channel interfaces
interface rcke_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] base_char;
   logic       end_of_sequence;

   modport source (output valid, output base_char, output end_of_sequence, input ready);
   modport sink (input valid, input base_char, input end_of_sequence, output ready);
endinterface

interface rcke_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [rcke_pkg::WINDOW_WIDTH-1:0] seed_value;
   logic                             seed_strand;
   logic [31:0]                      start_position;
   logic [7:0]                       family_tag;
   logic [5:0]                       seed_length;
   logic [31:0]                      document_tag;
   logic [31:0]                      sequence_tag;

   modport source (output valid, output seed_value, output seed_strand,
                   output start_position, output family_tag, output seed_length,
                   output document_tag, output sequence_tag, input ready);
   modport sink (input valid, input seed_value, input seed_strand,
                 input start_position, input family_tag, input seed_length,
                 input document_tag, input sequence_tag, output ready);
endinterface

interface rcke_csr_if;
   logic                                 valid;
   logic                                 ready;
   logic [rcke_pkg::CSR_INDEX_WIDTH-1:0] index;
   logic [rcke_pkg::CSR_DATA_WIDTH-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

### rtl/rolling_canonical_kmer_extractor_top.sv
// top level of the rolling canonical k-mer extractor
//
// req_if carries one ascii character per request plus an end-of-sequence flag.
// a/c/g/t in either case extend the rolling forward and reverse-complement
// windows; any other character clears them and the run of valid bases.
// from the k-th consecutive base on, each base produces one seed on
// rsp_if: the packed k-mer (smaller strand in canonical mode), the strand,
// the start position and the echoed tags.
// csr_if writes the five configuration registers by index; it is always
// ready and should be written only while no request is in flight.
// a seed is registered and appears on rsp_if in the cycle after its request is accepted.
// throughput: one request per cycle, set by the single result register;
// requests that produce no seed are absorbed at the same rate.
// when rsp_if stalls the result register holds and req_if.ready drops until
// the held seed is taken; a seed leaving frees room for a request that cycle.
// reset clears the windows, the run count, the position and the result
// valid flag, and restores k to 21 with canonical mode on.
module rolling_canonical_kmer_extractor_top #(
   parameter int POSITION_WIDTH = rcke_pkg::POSITION_WIDTH_DEFAULT,
   parameter int MAX_KMER = rcke_pkg::MAX_KMER_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   rcke_req_if.sink   req_if,
   rcke_rsp_if.source rsp_if,
   rcke_csr_if.sink   csr_if
);

   rcke_pkg::cfg_type  cfg;
   rcke_pkg::seed_type seed;
   logic               emit;
   logic               room;
   logic               accept;

   assign req_if.ready = room;
   assign accept = req_if.valid && room;

   rcke_csr u_csr (
      .clock  (clock),
      .reset  (reset),
      .csr_if (csr_if),
      .cfg    (cfg)
   );

   rcke_core #(
      .POSITION_WIDTH (POSITION_WIDTH),
      .MAX_KMER       (MAX_KMER)
   ) u_core (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .accept          (accept),
      .base_char       (req_if.base_char),
      .end_of_sequence (req_if.end_of_sequence),
      .emit            (emit),
      .seed            (seed)
   );

   rcke_out u_out (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .emit   (emit),
      .seed   (seed),
      .room   (room),
      .rsp_if (rsp_if)
   );

endmodule

### rtl/rcke_csr.sv
// configuration register file
module rcke_csr (
   input  logic              clock,
   input  logic              reset,
   rcke_csr_if.sink          csr_if,
   output rcke_pkg::cfg_type cfg
);

   rcke_pkg::cfg_type cfg_ff;
   rcke_pkg::cfg_type cfg_in;
   logic              write;

   assign csr_if.ready = 1'b1;
   assign write = csr_if.valid && csr_if.ready;

   always_comb begin
      cfg_in = cfg_ff;
      if (write) begin
         unique case (csr_if.index)
            rcke_pkg::CSR_KMER_LENGTH:     cfg_in.kmer_length = csr_if.data[5:0];
            rcke_pkg::CSR_CANONICAL_MODE:  cfg_in.canonical_mode = csr_if.data[0];
            rcke_pkg::CSR_SEED_FAMILY:     cfg_in.seed_family = csr_if.data[7:0];
            rcke_pkg::CSR_DOCUMENT_NUMBER: cfg_in.document_number = csr_if.data;
            rcke_pkg::CSR_SEQUENCE_NUMBER: cfg_in.sequence_number = csr_if.data;
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.kmer_length <= rcke_pkg::KMER_LENGTH_RESET;
         cfg_ff.canonical_mode <= rcke_pkg::CANONICAL_MODE_RESET;
         cfg_ff.seed_family <= '0;
         cfg_ff.document_number <= '0;
         cfg_ff.sequence_number <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

### rtl/rcke_core.sv
// rolling forward and reverse-complement windows, run count and seed selection
module rcke_core #(
   parameter int POSITION_WIDTH = rcke_pkg::POSITION_WIDTH_DEFAULT,
   parameter int MAX_KMER = rcke_pkg::MAX_KMER_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  rcke_pkg::cfg_type  cfg,
   input  logic               accept,
   input  logic [7:0]         base_char,
   input  logic               end_of_sequence,
   output logic               emit,
   output rcke_pkg::seed_type seed
);

   localparam int WW = rcke_pkg::WINDOW_WIDTH;
   localparam int PAIRS = rcke_pkg::PAIR_COUNT;
   localparam logic [6:0] KMER_MAX = 7'(MAX_KMER);

   logic [WW-1:0]             fwd_window_ff, fwd_window_in;
   logic [WW-1:0]             rev_window_ff, rev_window_in;
   logic [5:0]                valid_run_ff, valid_run_in;
   logic [POSITION_WIDTH-1:0] char_index_ff, char_index_in;

   rcke_pkg::base_type        base;
   logic                      k_ok;
   logic [WW-1:0]             keep_mask;
   logic [WW-1:0]             fwd_next, rev_next;
   logic [5:0]                run_next;
   logic                      pick_rev;
   logic [POSITION_WIDTH-1:0] start_full;

   assign base = rcke_pkg::base_decode(base_char);
   assign k_ok = (cfg.kmer_length != 6'd0) && ({1'b0, cfg.kmer_length} <= KMER_MAX);

   always_comb begin
      logic [WW-1:0] fwd_shift;
      logic [WW-1:0] rev_shift;
      logic [1:0]    comp;
      fwd_shift = {fwd_window_ff[WW-3:0], base.code};
      rev_shift = {2'b00, rev_window_ff[WW-1:2]};
      comp = ~base.code;
      for (int j = 0; j < PAIRS; j++) begin
         keep_mask[2*j +: 2] = (6'(j) < cfg.kmer_length) ? 2'b11 : 2'b00;
         fwd_next[2*j +: 2] = fwd_shift[2*j +: 2] & keep_mask[2*j +: 2];
         // new complemented base enters at pair k-1, the top pair of the k-mer
         rev_next[2*j +: 2] = (rev_shift[2*j +: 2]
                               | ((6'(j + 1) == cfg.kmer_length) ? comp : 2'b00))
                              & keep_mask[2*j +: 2];
      end
   end

   assign run_next = (valid_run_ff < rcke_pkg::RUN_LIMIT) ? valid_run_ff + 6'd1 : valid_run_ff;
   assign emit = base.is_base && k_ok && (run_next >= cfg.kmer_length);
   assign pick_rev = cfg.canonical_mode && (rev_next < fwd_next);
   assign start_full = char_index_ff + POSITION_WIDTH'(1) - POSITION_WIDTH'(cfg.kmer_length);

   always_comb begin
      seed.seed_value = pick_rev ? rev_next : fwd_next;
      seed.seed_strand = pick_rev;
      seed.start_position = 32'(start_full);
      seed.family_tag = cfg.seed_family;
      seed.seed_length = cfg.kmer_length;
      seed.document_tag = cfg.document_number;
      seed.sequence_tag = cfg.sequence_number;
   end

   always_comb begin
      fwd_window_in = fwd_window_ff;
      rev_window_in = rev_window_ff;
      valid_run_in = valid_run_ff;
      char_index_in = char_index_ff;
      if (accept) begin
         if (!base.is_base) begin
            fwd_window_in = '0;
            rev_window_in = '0;
            valid_run_in = '0;
         end else begin
            fwd_window_in = k_ok ? fwd_next : '0;
            rev_window_in = k_ok ? rev_next : '0;
            valid_run_in = run_next;
         end
         char_index_in = char_index_ff + POSITION_WIDTH'(1);
         if (end_of_sequence) begin
            fwd_window_in = '0;
            rev_window_in = '0;
            valid_run_in = '0;
            char_index_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_window_ff <= '0;
         rev_window_ff <= '0;
         valid_run_ff <= '0;
         char_index_ff <= '0;
      end else begin
         fwd_window_ff <= fwd_window_in;
         rev_window_ff <= rev_window_in;
         valid_run_ff <= valid_run_in;
         char_index_ff <= char_index_in;
      end
   end

   a_eos_clears: assert property (@(posedge clock) disable iff (reset)
      accept && end_of_sequence |=> fwd_window_ff == '0 && rev_window_ff == '0
                                    && valid_run_ff == '0 && char_index_ff == '0)
      else $error("state not cleared after end of sequence");

   a_non_base_clears_run: assert property (@(posedge clock) disable iff (reset)
      accept && !base.is_base |=> valid_run_ff == '0 && fwd_window_ff == '0)
      else $error("run not cleared after non-base character");

   a_run_saturates: assert property (@(posedge clock) disable iff (reset)
      valid_run_ff <= rcke_pkg::RUN_LIMIT)
      else $error("valid run above limit");

   a_window_masked: assert property (@(posedge clock) disable iff (reset)
      accept |=> ((fwd_window_ff | rev_window_ff) & ~$past(keep_mask)) == '0)
      else $error("window holds bases beyond k");

endmodule

### rtl/rcke_out.sv
// result register between the seed logic and the response channel
module rcke_out (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  logic               emit,
   input  rcke_pkg::seed_type seed,
   output logic               room,
   rcke_rsp_if.source         rsp_if
);

   logic               valid_ff, valid_in;
   rcke_pkg::seed_type seed_ff, seed_in;
   logic               taken;

   assign taken = rsp_if.valid && rsp_if.ready;
   assign room = !valid_ff || rsp_if.ready;

   always_comb begin
      valid_in = valid_ff;
      seed_in = seed_ff;
      if (accept) begin
         valid_in = emit;
         if (emit) begin
            seed_in = seed;
         end
      end else if (taken) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      seed_ff <= seed_in;
   end

   assign rsp_if.valid = valid_ff;
   assign rsp_if.seed_value = seed_ff.seed_value;
   assign rsp_if.seed_strand = seed_ff.seed_strand;
   assign rsp_if.start_position = seed_ff.start_position;
   assign rsp_if.family_tag = seed_ff.family_tag;
   assign rsp_if.seed_length = seed_ff.seed_length;
   assign rsp_if.document_tag = seed_ff.document_tag;
   assign rsp_if.sequence_tag = seed_ff.sequence_tag;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      accept |-> room)
      else $error("request accepted while result stalled");

   a_emit_shows: assert property (@(posedge clock) disable iff (reset)
      accept && emit |=> valid_ff && seed_ff == $past(seed))
      else $error("emitted seed not presented");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      valid_ff && !rsp_if.ready |=> valid_ff && $stable(seed_ff))
      else $error("stalled result lost");

endmodule
